### src/saf_pkg.sv
// ----------------------------------------------------------------------------
// saf_pkg
// Shared types, codes and constants of the signed advertisement filter.
// ----------------------------------------------------------------------------
package saf_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int SIG_BYTES_DEF    = 8;
  localparam int PACKET_BYTES_DEF = 26;

  localparam logic [7:0]  MAGIC_B0   = 8'hFF;
  localparam logic [7:0]  MAGIC_B1   = 8'hFF;
  localparam logic [7:0]  MAGIC_B2   = 8'h48;
  localparam logic [7:0]  MAGIC_B3   = 8'h42;
  localparam logic [31:0] MAGIC_WORD = {MAGIC_B3, MAGIC_B2, MAGIC_B1, MAGIC_B0};
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [31:0] HOLDOFF_RST = 32'd3000;
  localparam logic [23:0] BAL_LIM_RST = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLED = 3'd0,
    CFG_OWN_TARGET_ID  = 3'd1,
    CFG_EXP_HEADER     = 3'd2,
    CFG_HOLDOFF_MS     = 3'd3,
    CFG_BALANCE_LIMIT  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_IGNORE = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_FAIL   = 3'd3,
    ACT_SYNC   = 3'd4,
    ACT_PET    = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    RSN_OK       = 4'd0,
    RSN_DISABLED = 4'd1,
    RSN_LENGTH   = 4'd2,
    RSN_MAGIC    = 4'd3,
    RSN_VERSION  = 4'd4,
    RSN_NOT_MINE = 4'd5,
    RSN_RATE_LIM = 4'd6,
    RSN_BAD_MAC  = 4'd7,
    RSN_BALANCE  = 4'd8,
    RSN_REPLAY   = 4'd9,
    RSN_BAD_OP   = 4'd10
  } reason_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic emit;
  } saf_cmd_t;

  typedef struct packed {
    logic early_stop;
    logic win_empty;
    logic scan_last;
  } saf_status_t;

endpackage

### src/saf_ctrl.sv
// ----------------------------------------------------------------------------
// saf_ctrl
// Sequencer: take a transfer, run the checks, walk the replay window and
// hand the verdict to the output register.
// ----------------------------------------------------------------------------
module saf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  saf_pkg::saf_status_t status_i,
  output saf_pkg::saf_cmd_t    cmd_o
);

  saf_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == saf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= saf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      saf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = saf_pkg::ST_CHECK;
        end
      end
      saf_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_nxt   = saf_pkg::ST_EMIT;
        if (!status_i.early_stop && !status_i.win_empty) state_nxt = saf_pkg::ST_SCAN;
      end
      saf_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) state_nxt = saf_pkg::ST_DRAIN;
      end
      saf_pkg::ST_DRAIN: begin
        state_nxt = saf_pkg::ST_EMIT;
      end
      saf_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = saf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = saf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

endmodule

### src/saf_datapath.sv
// ----------------------------------------------------------------------------
// saf_datapath
// Configuration registers, item checks from length to opcode, replay window
// memory with its walk, bad-signature holdoff state and output register.
// ----------------------------------------------------------------------------
module saf_datapath #(
  parameter int WINDOW_DEPTH = saf_pkg::WINDOW_DEPTH_DEF,
  parameter int SIG_BYTES    = saf_pkg::SIG_BYTES_DEF,
  parameter int PACKET_BYTES = saf_pkg::PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [saf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [saf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                     in_packet_length,
  input  logic [31:0]                    in_magic_word,
  input  logic [7:0]                     in_header_byte,
  input  logic [7:0]                     in_opcode,
  input  logic [47:0]                    in_target_id,
  input  logic [23:0]                    in_sequence_nonce,
  input  logic [23:0]                    in_balance_value,
  input  logic [63:0]                    in_signature,
  input  logic [63:0]                    in_computed_mac,
  input  logic                           in_mac_valid,
  input  logic [31:0]                    in_now_ms,
  input  saf_pkg::saf_cmd_t              cmd_i,
  output saf_pkg::saf_status_t           status_o,
  output logic [2:0]                     out_result_action,
  output logic [3:0]                     out_reason_code,
  output logic [23:0]                    out_balance_out,
  output logic [23:0]                    out_sequence_out
);

  localparam int SIG_W  = 8 * SIG_BYTES;
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);

  // configuration
  logic        en_r;
  logic [47:0] own_id_r;
  logic [7:0]  exp_hdr_r;
  logic [31:0] holdoff_r;
  logic [23:0] bal_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 1'b1;
      own_id_r  <= '0;
      exp_hdr_r <= '0;
      holdoff_r <= saf_pkg::HOLDOFF_RST;
      bal_lim_r <= saf_pkg::BAL_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        saf_pkg::CFG_FILTER_ENABLED: en_r      <= cfg_data[0];
        saf_pkg::CFG_OWN_TARGET_ID:  own_id_r  <= cfg_data[47:0];
        saf_pkg::CFG_EXP_HEADER:     exp_hdr_r <= cfg_data[7:0];
        saf_pkg::CFG_HOLDOFF_MS:     holdoff_r <= cfg_data[31:0];
        saf_pkg::CFG_BALANCE_LIMIT:  bal_lim_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [7:0]       len_r;
  logic [31:0]      magic_r;
  logic [7:0]       hdr_r;
  logic [7:0]       op_r;
  logic [47:0]      target_r;
  logic [23:0]      seq_r;
  logic [23:0]      bal_r;
  logic [SIG_W-1:0] sig_r;
  logic [SIG_W-1:0] mac_r;
  logic             mac_ok_r;
  logic [31:0]      now_r;

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      len_r    <= in_packet_length;
      magic_r  <= in_magic_word;
      hdr_r    <= in_header_byte;
      op_r     <= in_opcode;
      target_r <= in_target_id;
      seq_r    <= in_sequence_nonce;
      bal_r    <= in_balance_value;
      sig_r    <= in_signature[SIG_W-1:0];
      mac_r    <= in_computed_mac[SIG_W-1:0];
      mac_ok_r <= in_mac_valid;
      now_r    <= in_now_ms;
    end
  end

  // early checks
  logic             bad_rep_r;
  logic [31:0]      last_bad_r;
  logic [31:0]      elapsed;
  saf_pkg::reason_t early_rsn, early_rsn_r;

  assign elapsed = now_r - last_bad_r;

  always_comb begin
    early_rsn = saf_pkg::RSN_OK;
    if (!en_r) early_rsn = saf_pkg::RSN_DISABLED;
    else if (len_r != 8'(PACKET_BYTES)) early_rsn = saf_pkg::RSN_LENGTH;
    else if (magic_r != saf_pkg::MAGIC_WORD) early_rsn = saf_pkg::RSN_MAGIC;
    else if ((hdr_r[3:0] & saf_pkg::NIBBLE_MASK) != (exp_hdr_r[3:0] & saf_pkg::NIBBLE_MASK))
      early_rsn = saf_pkg::RSN_MAGIC;
    else if (hdr_r[7:4] != exp_hdr_r[7:4]) early_rsn = saf_pkg::RSN_VERSION;
    else if (target_r != own_id_r) early_rsn = saf_pkg::RSN_NOT_MINE;
    else if (!mac_ok_r || (mac_r != sig_r)) begin
      if (bad_rep_r && (elapsed < holdoff_r)) early_rsn = saf_pkg::RSN_RATE_LIM;
      else early_rsn = saf_pkg::RSN_BAD_MAC;
    end else if (bal_r > bal_lim_r) early_rsn = saf_pkg::RSN_BALANCE;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.check) early_rsn_r <= early_rsn;
  end

  // replay window
  logic [SIG_W-1:0]  mem [WINDOW_DEPTH];
  logic [SIG_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic              hit_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  next_r;
  logic [FILL_W-1:0] fill_r;
  logic              record;

  always_ff @(posedge clk) begin
    if (cmd_i.scan) rd_data_r <= mem[idx_r];
    if (record) mem[next_r] <= sig_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      hit_r    <= 1'b0;
      idx_r    <= '0;
    end else begin
      rd_vld_r <= cmd_i.scan;
      if (cmd_i.check) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd_i.scan) idx_r <= idx_r + 1'b1;
        if (rd_vld_r && (rd_data_r == sig_r)) hit_r <= 1'b1;
      end
    end
  end

  assign status_o.early_stop = (early_rsn != saf_pkg::RSN_OK);
  assign status_o.win_empty  = (fill_r == '0);
  assign status_o.scan_last  = ((FILL_W'(idx_r) + 1'b1) == fill_r);

  // verdict
  saf_pkg::reason_t fin_rsn;
  saf_pkg::action_t fin_act;
  logic             op_ok;

  assign op_ok = (op_r >= 8'(saf_pkg::ACT_ADD)) && (op_r <= 8'(saf_pkg::ACT_PET));

  always_comb begin
    fin_rsn = early_rsn_r;
    if (early_rsn_r == saf_pkg::RSN_OK) begin
      if (hit_r) fin_rsn = saf_pkg::RSN_REPLAY;
      else if (!op_ok) fin_rsn = saf_pkg::RSN_BAD_OP;
    end
    case (fin_rsn)
      saf_pkg::RSN_OK:      fin_act = saf_pkg::action_t'(op_r[2:0]);
      saf_pkg::RSN_BAD_MAC: fin_act = saf_pkg::ACT_FAIL;
      default:              fin_act = saf_pkg::ACT_IGNORE;
    endcase
  end

  assign record = cmd_i.emit && (fin_rsn == saf_pkg::RSN_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      next_r     <= '0;
      bad_rep_r  <= 1'b0;
      last_bad_r <= '0;
    end else begin
      if (record) begin
        if (next_r == IDX_W'(WINDOW_DEPTH - 1)) next_r <= '0;
        else next_r <= next_r + 1'b1;
        if (fill_r != FILL_W'(WINDOW_DEPTH)) fill_r <= fill_r + 1'b1;
      end
      if (cmd_i.emit && (fin_rsn == saf_pkg::RSN_BAD_MAC)) begin
        bad_rep_r  <= 1'b1;
        last_bad_r <= now_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_result_action <= '0;
      out_reason_code   <= '0;
      out_balance_out   <= '0;
      out_sequence_out  <= '0;
    end else if (cmd_i.emit) begin
      out_result_action <= fin_act;
      out_reason_code   <= fin_rsn;
      out_balance_out   <= record ? bal_r : '0;
      out_sequence_out  <= record ? seq_r : '0;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");

  a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.scan |-> (FILL_W'(idx_r) < fill_r))
    else $error("window walk past fill");

  a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (record && (fill_r != FILL_W'(WINDOW_DEPTH))) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("fill did not advance on record");

  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ((out_balance_out != '0) || (out_sequence_out != '0)) |->
      (out_reason_code == saf_pkg::RSN_OK))
    else $error("balance or sequence reported on reject");

endmodule

### src/signed_advert_filter.sv
// ----------------------------------------------------------------------------
// signed_advert_filter
// Verdict engine for received signed advertisements.
// ----------------------------------------------------------------------------
// One input transfer carries a decoded advertisement with its externally
// computed MAC and the current millisecond time; one output transfer carries
// the verdict: action, reason, and balance and sequence when accepted.
// The cfg channel writes the five registers by index and is always ready;
// write it only while the block is idle.
// An item passes from the input transfer through the checks, the walk of the
// replay window over its F filled entries (1 to WINDOW_DEPTH), a drain step
// and the output register; the walk is skipped when an earlier check decides
// or the window is empty. The walk reads one window entry per cycle from a
// single-port memory. A new item is taken only once the last verdict is emitted.
// A result waits in the output register while the receiver stalls; the next
// item is taken and checked meanwhile and holds before its own output stage.
// Reset restores register defaults and empties the replay window.
// ----------------------------------------------------------------------------
module signed_advert_filter #(
  parameter int WINDOW_DEPTH = saf_pkg::WINDOW_DEPTH_DEF,
  parameter int SIG_BYTES    = saf_pkg::SIG_BYTES_DEF,
  parameter int PACKET_BYTES = saf_pkg::PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_packet_length,
  input  logic [31:0]                    in_magic_word,
  input  logic [7:0]                     in_header_byte,
  input  logic [7:0]                     in_opcode,
  input  logic [47:0]                    in_target_id,
  input  logic [23:0]                    in_sequence_nonce,
  input  logic [23:0]                    in_balance_value,
  input  logic [63:0]                    in_signature,
  input  logic [63:0]                    in_computed_mac,
  input  logic                           in_mac_valid,
  input  logic [31:0]                    in_now_ms,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_result_action,
  output logic [3:0]                     out_reason_code,
  output logic [23:0]                    out_balance_out,
  output logic [23:0]                    out_sequence_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [saf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [saf_pkg::CFG_DATA_W-1:0] cfg_data
);

  saf_pkg::saf_cmd_t    cmd;
  saf_pkg::saf_status_t status;

  assign cfg_ready = 1'b1;

  saf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  saf_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SIG_BYTES    (SIG_BYTES),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_packet_length  (in_packet_length),
    .in_magic_word     (in_magic_word),
    .in_header_byte    (in_header_byte),
    .in_opcode         (in_opcode),
    .in_target_id      (in_target_id),
    .in_sequence_nonce (in_sequence_nonce),
    .in_balance_value  (in_balance_value),
    .in_signature      (in_signature),
    .in_computed_mac   (in_computed_mac),
    .in_mac_valid      (in_mac_valid),
    .in_now_ms         (in_now_ms),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_result_action (out_result_action),
    .out_reason_code   (out_reason_code),
    .out_balance_out   (out_balance_out),
    .out_sequence_out  (out_sequence_out)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed advertisement filter.
// Advertisements are driven on the input channel and a verdict predictor,
// kept in step with the register writes, queues the expected action, reason,
// balance and sequence of each one. Directed tests cover every rejection
// reason, every opcode, the bad signature holdoff around time wrap and the
// replay window. Random traffic follows under several register settings and
// idling phases, and each verdict is checked in order as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [7:0]  length;
    logic [31:0] magic;
    logic [7:0]  header;
    logic [7:0]  opcode;
    logic [47:0] target;
    logic [23:0] nonce;
    logic [23:0] balance;
    logic [63:0] sig;
    logic [63:0] mac;
    logic        mac_ok;
    logic [31:0] now;
  } advert_t;

  typedef struct {
    saf_pkg::action_t action;
    saf_pkg::reason_t reason;
    logic [23:0]      balance;
    logic [23:0]      nonce;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_packet_length;
  logic [31:0] in_magic_word;
  logic [7:0] in_header_byte;
  logic [7:0] in_opcode;
  logic [47:0] in_target_id;
  logic [23:0] in_sequence_nonce;
  logic [23:0] in_balance_value;
  logic [63:0] in_signature;
  logic [63:0] in_computed_mac;
  logic in_mac_valid;
  logic [31:0] in_now_ms;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_result_action;
  logic [3:0] out_reason_code;
  logic [23:0] out_balance_out;
  logic [23:0] out_sequence_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [saf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [saf_pkg::CFG_DATA_W-1:0] cfg_data;

  logic        cfg_enabled;
  logic [47:0] cfg_own_id;
  logic [7:0]  cfg_header;
  logic [31:0] cfg_holdoff;
  logic [23:0] cfg_limit;

  logic [63:0] sig_window [saf_pkg::WINDOW_DEPTH_DEF];
  int unsigned window_fill;
  int unsigned window_next;
  logic [31:0] last_bad_ms;
  logic        bad_sig_seen;

  verdict_t    pending_verdicts [$];
  logic [63:0] sig_pool [$];
  logic [31:0] ms_clock;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned accepted_count;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  signed_advert_filter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_packet_length  (in_packet_length),
    .in_magic_word     (in_magic_word),
    .in_header_byte    (in_header_byte),
    .in_opcode         (in_opcode),
    .in_target_id      (in_target_id),
    .in_sequence_nonce (in_sequence_nonce),
    .in_balance_value  (in_balance_value),
    .in_signature      (in_signature),
    .in_computed_mac   (in_computed_mac),
    .in_mac_valid      (in_mac_valid),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_action (out_result_action),
    .out_reason_code   (out_reason_code),
    .out_balance_out   (out_balance_out),
    .out_sequence_out  (out_sequence_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               pending_verdicts.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic verdict_t judge_advert(advert_t a);
    verdict_t    v;
    logic        seen;
    logic [31:0] since_bad;
    v = '{saf_pkg::ACT_IGNORE, saf_pkg::RSN_OK, 24'd0, 24'd0};
    seen = 1'b0;
    since_bad = a.now - last_bad_ms;
    if (!cfg_enabled) v.reason = saf_pkg::RSN_DISABLED;
    else if (a.length != 8'(saf_pkg::PACKET_BYTES_DEF)) v.reason = saf_pkg::RSN_LENGTH;
    else if (a.magic != saf_pkg::MAGIC_WORD) v.reason = saf_pkg::RSN_MAGIC;
    else if ((a.header & saf_pkg::NIBBLE_MASK) != (cfg_header & saf_pkg::NIBBLE_MASK))
      v.reason = saf_pkg::RSN_MAGIC;
    else if (a.header[7:4] != cfg_header[7:4]) v.reason = saf_pkg::RSN_VERSION;
    else if (a.target != cfg_own_id) v.reason = saf_pkg::RSN_NOT_MINE;
    else if (!a.mac_ok || a.mac != a.sig) begin
      if (bad_sig_seen && since_bad < cfg_holdoff) begin
        v.reason = saf_pkg::RSN_RATE_LIM;
      end else begin
        last_bad_ms = a.now;
        bad_sig_seen = 1'b1;
        v.action = saf_pkg::ACT_FAIL;
        v.reason = saf_pkg::RSN_BAD_MAC;
      end
    end else if (a.balance > cfg_limit) v.reason = saf_pkg::RSN_BALANCE;
    else begin
      for (int i = 0; i < window_fill; i++)
        if (sig_window[i] == a.sig) seen = 1'b1;
      if (seen) v.reason = saf_pkg::RSN_REPLAY;
      else if (a.opcode < 8'(saf_pkg::ACT_ADD) || a.opcode > 8'(saf_pkg::ACT_PET))
        v.reason = saf_pkg::RSN_BAD_OP;
      else begin
        sig_window[window_next] = a.sig;
        window_next = (window_next + 1) % saf_pkg::WINDOW_DEPTH_DEF;
        if (window_fill < saf_pkg::WINDOW_DEPTH_DEF) window_fill++;
        v.action = saf_pkg::action_t'(a.opcode[2:0]);
        v.balance = a.balance;
        v.nonce = a.nonce;
      end
    end
    return v;
  endfunction

  function automatic advert_t good_advert(logic [63:0] sig, logic [7:0] op, logic [31:0] now);
    advert_t a;
    a.length = 8'(saf_pkg::PACKET_BYTES_DEF);
    a.magic = saf_pkg::MAGIC_WORD;
    a.header = cfg_header;
    a.opcode = op;
    a.target = cfg_own_id;
    a.nonce = 24'($urandom);
    a.balance = 24'($urandom_range(cfg_limit));
    a.sig = sig;
    a.mac = sig;
    a.mac_ok = 1'b1;
    a.now = now;
    return a;
  endfunction

  // well-formed adverts with random content, a share of broken ones and noise
  function automatic advert_t random_advert();
    advert_t     a;
    logic [63:0] sig;
    int unsigned pick;
    ms_clock += ($urandom_range(3) == 0) ? $urandom_range(4000) : $urandom_range(200);
    if (sig_pool.size() > 0 && $urandom_range(99) < 35) begin
      sig = sig_pool[$urandom_range(sig_pool.size() - 1)];
    end else begin
      sig = {$urandom, $urandom};
      sig_pool.push_back(sig);
      if (sig_pool.size() > 24) void'(sig_pool.pop_front());
    end
    pick = $urandom_range(99);
    a = good_advert(sig, 8'($urandom_range(saf_pkg::ACT_PET, saf_pkg::ACT_ADD)), ms_clock);
    if ($urandom_range(9) == 0) a.opcode = 8'($urandom);
    if ($urandom_range(6) == 0) a.balance = 24'($urandom);
    if (pick < 10) begin
      a.length = 8'($urandom);
      a.magic = $urandom;
      a.header = 8'($urandom);
      a.target = {16'($urandom), 32'($urandom)};
      a.mac = {$urandom, $urandom};
      a.mac_ok = 1'($urandom);
      a.now = $urandom;
    end else if (pick < 32) begin
      case ($urandom_range(7))
        0: a.length = 8'($urandom);
        1: a.magic[$urandom_range(31)] ^= 1'b1;
        2: a.header[$urandom_range(7)] ^= 1'b1;
        3: a.target[$urandom_range(47)] ^= 1'b1;
        4: a.mac[$urandom_range(63)] ^= 1'b1;
        5: a.mac_ok = 1'b0;
        default: begin
          a.mac = {$urandom, $urandom};
          a.mac_ok = 1'($urandom);
        end
      endcase
    end
    return a;
  endfunction

  task automatic send_advert(advert_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_packet_length <= a.length;
    in_magic_word <= a.magic;
    in_header_byte <= a.header;
    in_opcode <= a.opcode;
    in_target_id <= a.target;
    in_sequence_nonce <= a.nonce;
    in_balance_value <= a.balance;
    in_signature <= a.sig;
    in_computed_mac <= a.mac;
    in_mac_valid <= a.mac_ok;
    in_now_ms <= a.now;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(judge_advert(a));
    sent_count++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(logic en, logic [47:0] id, logic [7:0] hdr,
                                logic [31:0] holdoff, logic [23:0] limit);
    saf_pkg::cfg_idx_t              reg_sel;
    logic [saf_pkg::CFG_DATA_W-1:0] data;
    wait_idle();
    reg_sel = reg_sel.first();
    repeat (reg_sel.num()) begin
      case (reg_sel)
        saf_pkg::CFG_FILTER_ENABLED: data = saf_pkg::CFG_DATA_W'(en);
        saf_pkg::CFG_OWN_TARGET_ID:  data = id;
        saf_pkg::CFG_EXP_HEADER:     data = saf_pkg::CFG_DATA_W'(hdr);
        saf_pkg::CFG_HOLDOFF_MS:     data = saf_pkg::CFG_DATA_W'(holdoff);
        default:                     data = saf_pkg::CFG_DATA_W'(limit);
      endcase
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= reg_sel;
      cfg_data <= data;
      do @(posedge clk); while (!cfg_ready);
      case (reg_sel)
        saf_pkg::CFG_FILTER_ENABLED: cfg_enabled = data[0];
        saf_pkg::CFG_OWN_TARGET_ID:  cfg_own_id = data[47:0];
        saf_pkg::CFG_EXP_HEADER:     cfg_header = data[7:0];
        saf_pkg::CFG_HOLDOFF_MS:     cfg_holdoff = data[31:0];
        default:                     cfg_limit = data[23:0];
      endcase
      reg_sel = reg_sel.next();
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_verdict
    verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected verdict: action %0d reason %0d bal %h seq %h",
                   out_result_action, out_reason_code, out_balance_out, out_sequence_out);
      end else begin
        v = pending_verdicts.pop_front();
        checked_count++;
        if (v.reason == saf_pkg::RSN_OK) accepted_count++;
        if (out_result_action !== v.action || out_reason_code !== v.reason ||
            out_balance_out !== v.balance || out_sequence_out !== v.nonce) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("verdict %0d: exp act %0d rsn %0d bal %h seq %h, got %0d %0d %h %h",
                     checked_count, v.action, v.reason, v.balance, v.nonce,
                     out_result_action, out_reason_code, out_balance_out, out_sequence_out);
        end
      end
    end
  end

  // register defaults straight after reset
  task automatic test_reset_defaults();
    advert_t a;
    send_advert(good_advert(64'h0F1E_2D3C_4B5A_6978, 8'(saf_pkg::ACT_ADD), 32'd100));
    send_advert(good_advert(64'h0F1E_2D3C_4B5A_6978, 8'(saf_pkg::ACT_ADD), 32'd105));
    a = good_advert(64'h0000_0000_0000_0001, 8'(saf_pkg::ACT_SUB), 32'd110);
    a.mac = 64'd0;
    send_advert(a);
    a.now = 32'd120;
    send_advert(a);
    a = good_advert(64'hFFFF_FFFF_FFFF_FFFF, 8'(saf_pkg::ACT_PET), 32'd130);
    a.balance = 24'hFF_FFFF;
    send_advert(a);
  endtask

  task automatic test_directed_checks();
    advert_t     a;
    logic [63:0] base;
    base = 64'h0123_4567_89AB_CD00;
    apply_settings(1'b1, 48'hA5C3_0F12_7E81, 8'h3A, 32'd1000, 24'h80_0000);
    a = good_advert(base, 8'(saf_pkg::ACT_ADD), 32'd1000);
    a.length = 8'd0;
    send_advert(a);
    a.length = 8'hFF;
    send_advert(a);
    a.length = 8'(saf_pkg::PACKET_BYTES_DEF - 1);
    send_advert(a);
    a = good_advert(base, 8'(saf_pkg::ACT_ADD), 32'd1000);
    a.magic[31:24] = 8'h43;
    send_advert(a);
    a.magic = 32'd0;
    send_advert(a);
    a = good_advert(base, 8'(saf_pkg::ACT_ADD), 32'd1000);
    a.header = 8'h3B;
    send_advert(a);
    a.header = 8'hBA;
    send_advert(a);
    a.header = 8'h3A;
    a.target[0] ^= 1'b1;
    send_advert(a);
    a.target = cfg_own_id ^ 48'h8000_0000_0000;
    send_advert(a);
    a = good_advert(base, 8'(saf_pkg::ACT_ADD), 32'd1000);
    a.balance = 24'h80_0001;
    send_advert(a);
    a.balance = 24'h80_0000;
    send_advert(a);
    for (int op = saf_pkg::ACT_SUB; op <= saf_pkg::ACT_PET; op++)
      send_advert(good_advert(base + 64'(op), 8'(op), 32'd1000));
    send_advert(good_advert(base, 8'(saf_pkg::ACT_SYNC), 32'd1000));
    send_advert(good_advert(base + 64'h10, 8'd0, 32'd1000));
    send_advert(good_advert(base + 64'h11, 8'd6, 32'd1000));
    send_advert(good_advert(base + 64'h12, 8'hFF, 32'd1000));
    // holdoff edge, then across the wrap of the millisecond time
    a = good_advert(base + 64'h20, 8'(saf_pkg::ACT_ADD), 32'd5000);
    a.mac[63] ^= 1'b1;
    send_advert(a);
    a.mac = a.sig;
    a.mac_ok = 1'b0;
    a.now = 32'd5500;
    send_advert(a);
    a.now = 32'd5999;
    send_advert(a);
    a.now = 32'd6000;
    send_advert(a);
    a.now = 32'hFFFF_FF00;
    send_advert(a);
    a.now = 32'h0000_0100;
    send_advert(a);
    send_advert(good_advert(base + 64'h20, 8'(saf_pkg::ACT_ADD), 32'h0000_0200));
  endtask

  task automatic test_holdoff_and_limit_extremes();
    advert_t a;
    apply_settings(1'b1, 48'hFFFF_FFFF_FFFF, 8'hFF, 32'd0, 24'd0);
    a = good_advert(64'hDEAD_0000_0000_0001, 8'(saf_pkg::ACT_FAIL), 32'd777);
    a.balance = 24'd1;
    send_advert(a);
    a.balance = 24'd0;
    send_advert(a);
    a.mac_ok = 1'b0;
    send_advert(a);
    send_advert(a);
    apply_settings(1'b1, 48'd0, 8'h00, 32'hFFFF_FFFF, 24'hFF_FFFF);
    a = good_advert(64'hDEAD_0000_0000_0002, 8'(saf_pkg::ACT_ADD), 32'h8000_0000);
    a.mac = ~a.sig;
    send_advert(a);
    a.now = 32'h8000_0001;
    send_advert(a);
    a.now = 32'h7FFF_FFFF;
    send_advert(a);
    a.now = 32'h7FFF_FFFE;
    send_advert(a);
  endtask

  task automatic test_filter_disabled();
    apply_settings(1'b0, 48'h1234_5678_9ABC, 8'h21, 32'd3000, 24'hFF_FFFF);
    send_advert(good_advert(64'hBEEF_0000_0000_0003, 8'(saf_pkg::ACT_ADD), 32'd10));
    send_advert(good_advert(64'hBEEF_0000_0000_0004, 8'hFF, 32'd20));
    send_advert(random_advert());
  endtask

  task automatic test_random_traffic();
    int unsigned sel;
    logic [47:0] id;
    logic [7:0]  hdr;
    logic [31:0] holdoff;
    logic [23:0] limit;
    for (int phase = 0; phase < 4; phase++) begin
      for (int part = 0; part < 2; part++) begin
        sel = phase * 2 + part;
        id = {16'($urandom), 32'($urandom)};
        hdr = 8'($urandom);
        holdoff = $urandom_range(8000, 100);
        limit = 24'($urandom_range(24'hFF_FFFF, 24'h40_0000));
        case (sel)
          0: begin holdoff = 32'd3000; limit = 24'hFF_FFFF; end
          1: begin id = 48'd0; hdr = 8'h00; holdoff = 32'd0; end
          2: begin id = 48'hFFFF_FFFF_FFFF; hdr = 8'hFF; holdoff = 32'hFFFF_FFFF; end
          3: limit = 24'd0;
          default: ;
        endcase
        apply_settings(1'b1, id, hdr, holdoff, limit);
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
          default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
        ms_clock = (sel == 2 || sel == 5) ? 32'hFFF8_0000 : $urandom;
        repeat (225) send_advert(random_advert());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_packet_length = '0;
    in_magic_word = '0;
    in_header_byte = '0;
    in_opcode = '0;
    in_target_id = '0;
    in_sequence_nonce = '0;
    in_balance_value = '0;
    in_signature = '0;
    in_computed_mac = '0;
    in_mac_valid = 1'b0;
    in_now_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_enabled = 1'b1;
    cfg_own_id = 48'd0;
    cfg_header = 8'd0;
    cfg_holdoff = saf_pkg::HOLDOFF_RST;
    cfg_limit = saf_pkg::BAL_LIM_RST;
    window_fill = 0;
    window_next = 0;
    last_bad_ms = 32'd0;
    bad_sig_seen = 1'b0;
    ms_clock = 32'd0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent_count = 0;
    checked_count = 0;
    accepted_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_checks();
    test_holdoff_and_limit_extremes();
    test_filter_disabled();
    test_random_traffic();

    wait_idle();
    repeat (40) @(posedge clk);
    $display("%0d adverts sent under 13 register settings and 4 idling phases", sent_count);
    $display("%0d verdicts checked, %0d accepted, %0d mismatches", checked_count,
             accepted_count, mismatch_count);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
